// ===== rtl/pgba_pkg.sv =====
// Shared types and constants for the periodic grid bin averager.
`timescale 1ns / 1ps

package pgba_pkg;

    localparam int MAX_DIM_DEF  = 32;
    localparam int CHANNELS_DEF = 8;

    localparam int SUM_W   = 56;
    localparam int COUNT_W = 24;
    localparam int VALUE_W = 32;
    localparam int COORD_W = 16;
    localparam int SIZE_REG_W = 6;
    localparam int INDEX_W = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 6'd32;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_DROPPED = 3'd1,
        ST_FULL    = 3'd2,
        ST_READ_OK = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_FIX,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_READ,
        S_EXEC,
        S_DIV,
        S_QOUT
    } t_state;

endpackage

// ===== rtl/periodic_grid_bin_averager_unit.sv =====
// Top level: per-channel 3D grid of running sums and counts with cell mean readout.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive the i_ fields and raise start; the request is taken
//   at a rising edge where start is high and busy is low. One request at a time.
//   Result channel: o_done is high for exactly one cycle with o_status,
//   o_mean_value, o_sample_count and o_cell_index. The receiver cannot stall.
//   Config: i_cfg_we writes i_cfg_data[5:0] to size register i_cfg_idx
//   (0 x, 1 y, 2 z; index 3 ignored). Write only while the block is idle.
// Sequence
//   Coordinate wrap runs one bit per cycle for x, y and z in parallel remainder
//   loops, then fixup, two multiply-adds for the cell, one for the slot
//   address, a registered memory read and the read-modify-write.
//   Add and read of an empty cell end there. Read of a nonempty cell adds a
//   56-step restoring divider plus sign fixup. busy drops the cycle o_done
//   rises.
// Reset
//   Sizes go to 32. The state memory is swept to zero, one entry a cycle,
//   over all CHANNELS * MAX_DIM^3 entries (262144 at defaults); busy stays high.

module periodic_grid_bin_averager_unit #(
    parameter int MAX_DIM  = pgba_pkg::MAX_DIM_DEF,
    parameter int CHANNELS = pgba_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic [2:0]                         i_channel,
    input  logic signed [pgba_pkg::COORD_W-1:0] i_cell_x,
    input  logic signed [pgba_pkg::COORD_W-1:0] i_cell_y,
    input  logic signed [pgba_pkg::COORD_W-1:0] i_cell_z,
    input  logic signed [pgba_pkg::VALUE_W-1:0] i_sample_value,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic signed [pgba_pkg::VALUE_W-1:0] o_mean_value,
    output logic [pgba_pkg::COUNT_W-1:0]       o_sample_count,
    output logic [pgba_pkg::INDEX_W-1:0]       o_cell_index,
    input  logic                               i_cfg_we,
    input  logic [pgba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pgba_pkg::SIZE_REG_W-1:0]    i_cfg_data
);

    localparam int SW    = $clog2(MAX_DIM + 1);       // holds a size up to MAX_DIM
    localparam int RW    = SW + 1;                    // partial remainder
    localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int CIW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DEPTH = CHANNELS * CELLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW    = pgba_pkg::SUM_W + pgba_pkg::COUNT_W;
    localparam int SUMW  = pgba_pkg::SUM_W;
    localparam int CNTW  = pgba_pkg::COUNT_W;
    localparam int CW    = pgba_pkg::COORD_W;

    // ---------------- helpers ----------------
    function automatic logic [SW-1:0] eff_size(input logic [pgba_pkg::SIZE_REG_W-1:0] reg_v);
        logic [SW-1:0] s;
        if (reg_v == '0) begin
            s = SW'(1);
        end else if (32'(reg_v) > 32'(MAX_DIM)) begin
            s = SW'(MAX_DIM);
        end else begin
            s = SW'(reg_v);
        end
        return s;
    endfunction

    // channel modulo CHANNELS on a 3-bit value: at most eight subtract steps
    function automatic logic [CHW-1:0] ch_reduce(input logic [2:0] ch);
        logic [4:0] r;
        r = 5'(ch);
        for (int k = 0; k < 8; k++) begin
            if (32'(r) >= 32'(CHANNELS)) begin
                r = r - 5'(CHANNELS);
            end
        end
        return CHW'(r);
    endfunction

    function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] rem, input logic b,
                                               input logic [SW-1:0] s);
        logic [RW-1:0] t;
        t = {rem[RW-2:0], b};
        if (t >= {1'b0, s}) begin
            t = t - {1'b0, s};
        end
        return t;
    endfunction

    // ---------------- config registers ----------------
    logic [pgba_pkg::SIZE_REG_W-1:0] r_size_x, r_size_y, r_size_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= pgba_pkg::SIZE_RESET;
            r_size_y <= pgba_pkg::SIZE_RESET;
            r_size_z <= pgba_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            priority case (i_cfg_idx)
                pgba_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data;
                pgba_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data;
                pgba_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- control ----------------
    pgba_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr;
    logic [5:0]       r_step;
    logic             w_accept;

    assign w_accept = start && !busy;

    // request fields held for the whole operation
    logic             r_req;
    logic [CHW-1:0]   r_ch;
    logic [CW-1:0]    r_mag_x, r_mag_y, r_mag_z;   // magnitudes, shifted out MSB first
    logic             r_neg_x, r_neg_y, r_neg_z;
    logic             r_drop;
    logic signed [pgba_pkg::VALUE_W-1:0] r_val;
    logic [SW-1:0]    r_sx, r_sy, r_sz;
    logic [RW-1:0]    r_rx, r_ry, r_rz;
    logic [SW-1:0]    r_x, r_y, r_z;
    logic [CIW-1:0]   r_t1, r_cell;
    logic [AW-1:0]    r_slot;

    // divider
    logic [SUMW-1:0]  r_dvd;
    logic [CNTW-1:0]  r_rem, r_dsr;
    logic             r_qneg;
    logic [CNTW:0]    w_dtry;
    logic             w_dge;

    // memory
    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rd;
    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [DW-1:0]    w_wd;

    logic signed [SUMW-1:0] w_sum;
    logic [CNTW-1:0]        w_cnt;
    logic                   w_full;

    assign w_sum  = r_rd[DW-1:CNTW];
    assign w_cnt  = r_rd[CNTW-1:0];
    assign w_full = (w_cnt == pgba_pkg::COUNT_MAX);

    assign w_dtry = {r_rem, r_dvd[SUMW-1]};
    assign w_dge  = (w_dtry >= {1'b0, r_dsr});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pgba_pkg::S_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = pgba_pkg::S_IDLE;
            pgba_pkg::S_IDLE:  if (start) n_state = pgba_pkg::S_WRAP;
            pgba_pkg::S_WRAP:  if (r_step == 6'(CW - 1)) n_state = pgba_pkg::S_FIX;
            pgba_pkg::S_FIX:   n_state = pgba_pkg::S_MUL1;
            pgba_pkg::S_MUL1:  n_state = pgba_pkg::S_MUL2;
            pgba_pkg::S_MUL2:  n_state = pgba_pkg::S_MUL3;
            pgba_pkg::S_MUL3:  n_state = pgba_pkg::S_READ;
            pgba_pkg::S_READ:  n_state = pgba_pkg::S_EXEC;
            pgba_pkg::S_EXEC: begin
                if (r_req == pgba_pkg::REQ_READ && w_cnt != '0) n_state = pgba_pkg::S_DIV;
                else n_state = pgba_pkg::S_IDLE;
            end
            pgba_pkg::S_DIV:   if (r_step == 6'(SUMW - 1)) n_state = pgba_pkg::S_QOUT;
            pgba_pkg::S_QOUT:  n_state = pgba_pkg::S_IDLE;
            default:           n_state = pgba_pkg::S_IDLE;
        endcase
    end

    // control outputs: busy and memory write port
    always_comb begin
        busy = (r_state != pgba_pkg::S_IDLE);
        w_we = 1'b0;
        w_wa = r_slot;
        w_wd = r_rd;
        unique case (r_state)
            pgba_pkg::S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
                w_wd = '0;
            end
            pgba_pkg::S_EXEC: begin
                if (r_req == pgba_pkg::REQ_ADD && !r_drop && !w_full) begin
                    w_we = 1'b1;
                    w_wd = {w_sum + SUMW'(r_val), w_cnt + CNTW'(1)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgba_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == pgba_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
        end
    end

    // state memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[r_slot];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pgba_pkg::S_IDLE: begin
                r_step  <= '0;
                r_req   <= i_req_type;
                r_ch    <= ch_reduce(i_channel);
                r_neg_x <= i_cell_x[CW-1];
                r_neg_y <= i_cell_y[CW-1];
                r_neg_z <= i_cell_z[CW-1];
                r_mag_x <= i_cell_x[CW-1] ? CW'(-i_cell_x) : CW'(i_cell_x);
                r_mag_y <= i_cell_y[CW-1] ? CW'(-i_cell_y) : CW'(i_cell_y);
                r_mag_z <= i_cell_z[CW-1] ? CW'(-i_cell_z) : CW'(i_cell_z);
                // add drops any y outside [0, size_y)
                r_drop  <= i_cell_y[CW-1] ||
                           (CW'(i_cell_y) >= CW'(eff_size(r_size_y)));
                r_val   <= i_sample_value;
                r_sx    <= eff_size(r_size_x);
                r_sy    <= eff_size(r_size_y);
                r_sz    <= eff_size(r_size_z);
                r_rx    <= '0;
                r_ry    <= '0;
                r_rz    <= '0;
            end
            pgba_pkg::S_WRAP: begin
                r_rx    <= mod_step(r_rx, r_mag_x[CW-1], r_sx);
                r_ry    <= mod_step(r_ry, r_mag_y[CW-1], r_sy);
                r_rz    <= mod_step(r_rz, r_mag_z[CW-1], r_sz);
                r_mag_x <= {r_mag_x[CW-2:0], 1'b0};
                r_mag_y <= {r_mag_y[CW-2:0], 1'b0};
                r_mag_z <= {r_mag_z[CW-2:0], 1'b0};
                r_step  <= (r_step == 6'(CW - 1)) ? '0 : r_step + 6'd1;
            end
            pgba_pkg::S_FIX: begin
                // negative operand with nonzero remainder folds to size - rem
                r_x <= (r_neg_x && r_rx != '0) ? r_sx - SW'(r_rx) : SW'(r_rx);
                r_y <= (r_neg_y && r_ry != '0) ? r_sy - SW'(r_ry) : SW'(r_ry);
                r_z <= (r_neg_z && r_rz != '0) ? r_sz - SW'(r_rz) : SW'(r_rz);
            end
            pgba_pkg::S_MUL1: r_t1   <= CIW'(r_z) * CIW'(r_sy) + CIW'(r_y);
            pgba_pkg::S_MUL2: r_cell <= r_t1 * CIW'(r_sx) + CIW'(r_x);
            pgba_pkg::S_MUL3: r_slot <= AW'(r_ch) * AW'(CELLS) + AW'(r_cell);
            pgba_pkg::S_EXEC: begin
                r_step <= '0;
                r_rem  <= '0;
                r_dsr  <= w_cnt;
                r_qneg <= w_sum[SUMW-1];
                r_dvd  <= w_sum[SUMW-1] ? SUMW'(-w_sum) : SUMW'(w_sum);
            end
            pgba_pkg::S_DIV: begin
                r_rem  <= w_dge ? CNTW'(w_dtry - {1'b0, r_dsr}) : CNTW'(w_dtry);
                r_dvd  <= {r_dvd[SUMW-2:0], w_dge};
                r_step <= r_step + 6'd1;
            end
            default: ;
        endcase
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == pgba_pkg::S_QOUT) ||
                      (r_state == pgba_pkg::S_EXEC && n_state == pgba_pkg::S_IDLE);
        end
        if (r_state == pgba_pkg::S_EXEC) begin
            o_cell_index   <= pgba_pkg::INDEX_W'(r_cell);
            o_mean_value   <= '0;
            o_sample_count <= w_cnt;
            if (r_req == pgba_pkg::REQ_ADD) begin
                if (r_drop) begin
                    o_status <= pgba_pkg::ST_DROPPED;
                end else if (w_full) begin
                    o_status <= pgba_pkg::ST_FULL;
                end else begin
                    o_status       <= pgba_pkg::ST_ADDED;
                    o_sample_count <= w_cnt + CNTW'(1);
                end
            end else begin
                o_status <= pgba_pkg::ST_EMPTY;
            end
        end else if (r_state == pgba_pkg::S_QOUT) begin
            o_status     <= pgba_pkg::ST_READ_OK;
            o_mean_value <= r_qneg ? pgba_pkg::VALUE_W'(-r_dvd)
                                   : pgba_pkg::VALUE_W'(r_dvd);
        end
    end

endmodule

// ===== rtl/pgba_chk.sv =====
// Port-level checker for the grid bin averager, bound to the top level.
`timescale 1ns / 1ps

module pgba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [31:0] o_mean_value,
    input logic [23:0] o_sample_count
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted request did not raise busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while still busy");

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != pgba_pkg::ST_READ_OK |-> o_mean_value == '0)
        else $error("mean nonzero outside read ok");

    a_added_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == pgba_pkg::ST_ADDED |-> o_sample_count != '0)
        else $error("add reported zero count");

endmodule

bind periodic_grid_bin_averager_unit pgba_chk u_pgba_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_mean_value   (o_mean_value),
    .o_sample_count (o_sample_count)
);

// ===== tb/testbench.sv =====
// Testbench for the periodic grid bin averager: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;
    import pgba_pkg::*;

    // Watchdog: cycles without any accepted request or result.
    // The reset sweep holds busy high while it clears 262144 entries.
    localparam int STALL_LIMIT = 1000000;
    localparam int N_RANDOM    = 400;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        mean;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] index;
    } bin_result_t;

    typedef struct {
        logic        req;
        logic [2:0]  ch;
        int          x, y, z;
        logic [31:0] val;
        bit          typed;     // expected result typed in below
        bin_result_t res;
    } table_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_req_type = 1'b0;
    logic [2:0] i_channel = '0;
    logic signed [COORD_W-1:0] i_cell_x = '0, i_cell_y = '0, i_cell_z = '0;
    logic signed [VALUE_W-1:0] i_sample_value = '0;
    logic o_done;
    logic [2:0] o_status;
    logic signed [VALUE_W-1:0] o_mean_value;
    logic [COUNT_W-1:0] o_sample_count;
    logic [INDEX_W-1:0] o_cell_index;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SIZE_REG_W-1:0] i_cfg_data = '0;

    periodic_grid_bin_averager_unit uut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---- predictor state: size registers and sparse copy of the grid ----
    logic [SIZE_REG_W-1:0] size_reg [3];
    longint bin_sum [int];
    int     bin_cnt [int];

    bin_result_t pending_results [$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  accepted_now;

    // Zero means one cell, anything above 32 saturates.
    function automatic int eff_dim(logic [SIZE_REG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(r);
    endfunction

    function automatic int wrap_mod(int c, int s);
        int r;
        r = c % s;
        if (r < 0) r += s;
        return r;
    endfunction

    // Applies one request to the grid copy and returns what the block should report.
    function automatic bin_result_t grid_apply(logic req, logic [2:0] ch, int x0, int y0,
                                               int z0, logic [31:0] val);
        int sx, sy, sz, x, y, z, cell_addr, key, cnt;
        longint q;
        bin_result_t r;
        sx = eff_dim(size_reg[CFG_SIZE_X]);
        sy = eff_dim(size_reg[CFG_SIZE_Y]);
        sz = eff_dim(size_reg[CFG_SIZE_Z]);
        x = wrap_mod(x0, sx);
        y = wrap_mod(y0, sy);
        z = wrap_mod(z0, sz);
        cell_addr = (z * sy + y) * sx + x;
        key = int'(ch) * 32768 + cell_addr;
        cnt = bin_cnt.exists(key) ? bin_cnt[key] : 0;
        r.mean = '0;
        if (req == REQ_ADD) begin
            if (y != y0) begin
                r.status = ST_DROPPED;
            end else if (cnt >= int'(COUNT_MAX)) begin
                r.status = ST_FULL;
            end else begin
                bin_sum[key] = (bin_sum.exists(key) ? bin_sum[key] : 0)
                               + longint'($signed(val));
                cnt++;
                bin_cnt[key] = cnt;
                r.status = ST_ADDED;
            end
        end else if (cnt == 0) begin
            r.status = ST_EMPTY;
        end else begin
            q = bin_sum[key] / longint'(cnt);   // truncates toward zero
            r.mean = q[31:0];
            r.status = ST_READ_OK;
        end
        r.count = cnt[COUNT_W-1:0];
        r.index = cell_addr[INDEX_W-1:0];
        return r;
    endfunction

    // ---- result checker: outputs sampled at the rising edge ----
    always @(posedge i_clk) begin
        bin_result_t want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_mean_value !== want.mean) begin
                    $display("%0t: mean exp %h got %h", $time, want.mean, o_mean_value);
                    errors++;
                end
                if (o_sample_count !== want.count) begin
                    $display("%0t: count exp %0d got %0d", $time, want.count,
                             o_sample_count);
                    errors++;
                end
                if (o_cell_index !== want.index) begin
                    $display("%0t: index exp %0d got %0d", $time, want.index,
                             o_cell_index);
                    errors++;
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        if (accepted_now || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---- request driver: burst/gap pattern on the sender side ----
    int burst_left = 0;

    task automatic send_request(logic req, logic [2:0] ch, int x, int y, int z,
                                logic [31:0] val, bit typed, bin_result_t typed_res);
        bin_result_t got;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_req_type = req;
        i_channel = ch;
        i_cell_x = x[15:0];
        i_cell_y = y[15:0];
        i_cell_z = z[15:0];
        i_sample_value = val;
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        accepted_now = 1'b1;
        got = grid_apply(req, ch, $signed(x[15:0]), $signed(y[15:0]), $signed(z[15:0]),
                         val);
        pending_results.push_back(typed ? typed_res : got);
        @(negedge i_clk);
        accepted_now = 1'b0;
        start = 1'b0;
    endtask

    // Sender holds off until every pending result is back, then a short settle.
    task automatic drain;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_REG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx <= CFG_SIZE_Z) size_reg[idx] = data;
    endtask

    function automatic int pick_coord(int span);
        // Mostly near the grid so cells get revisited, sometimes full range.
        if ($urandom_range(0, 4) == 0) return $signed(16'($urandom()));
        return $urandom_range(0, 2 * span + 1) - span;
    endfunction

    // ---- directed table ----
    table_row_t dir_rows [$];

    function automatic table_row_t row(logic req, logic [2:0] ch, int x, int y, int z,
                                       logic [31:0] val, bit typed = 0,
                                       logic [2:0] st = ST_ADDED, logic [31:0] mean = 0,
                                       int cnt = 0, int idx = 0);
        table_row_t r;
        r.req = req; r.ch = ch; r.x = x; r.y = y; r.z = z; r.val = val;
        r.typed = typed;
        r.res = '{st, mean, cnt[COUNT_W-1:0], idx[INDEX_W-1:0]};
        return r;
    endfunction

    initial begin
        int sizes [6][3];
        int span, y;
        logic req;
        sizes = '{'{32, 32, 32}, '{0, 0, 0}, '{63, 40, 33}, '{5, 3, 7}, '{1, 32, 2},
                  '{0, 0, 0}};
        size_reg = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
        accepted_now = 1'b0;

        // After reset all sizes are 32: typed expectations follow directly.
        dir_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(REQ_ADD, 0, 0, 0, 0, 32'h7fffffff, 1, ST_ADDED, 0, 1, 0));
        dir_rows.push_back(row(REQ_ADD, 0, 0, 0, 0, 32'h7fffffff, 1, ST_ADDED, 0, 2, 0));
        dir_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 1, ST_READ_OK, 32'h7fffffff, 2, 0));
        dir_rows.push_back(row(REQ_ADD, 7, -1, 31, -1, 32'h80000000, 1, ST_ADDED, 0, 1,
                               32767));
        dir_rows.push_back(row(REQ_READ, 7, -1, -1, -1, 0, 1, ST_READ_OK, 32'h80000000, 1,
                               32767));
        // y out of range on add: dropped, y wraps for the reported cell
        dir_rows.push_back(row(REQ_ADD, 3, 32767, 32, 0, 5, 1, ST_DROPPED, 0, 0, 31));
        dir_rows.push_back(row(REQ_ADD, 3, -32768, -1, 0, 5, 1, ST_DROPPED, 0, 0, 992));
        dir_rows.push_back(row(REQ_ADD, 3, 0, -32768, 0, 5, 1, ST_DROPPED, 0, 0, 0));
        dir_rows.push_back(row(REQ_ADD, 3, 0, 32767, 0, 5, 1, ST_DROPPED, 0, 0, 992));
        // read wraps y too
        dir_rows.push_back(row(REQ_READ, 3, 0, -32768, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        // mean of mixed signs, one cell reached through wrapped coordinates
        dir_rows.push_back(row(REQ_ADD, 5, 3, 4, 5, 32'hfffffffd));
        dir_rows.push_back(row(REQ_ADD, 5, 35, 4, -27, 32'h00000001));
        dir_rows.push_back(row(REQ_ADD, 5, 3, 4, 5, 32'hffffffff));
        dir_rows.push_back(row(REQ_READ, 5, -29, 36, 37, 32'h12345678));
        dir_rows.push_back(row(REQ_ADD, 1, 32767, 0, 32767, 32'h0000ffff));
        dir_rows.push_back(row(REQ_READ, 1, -1, 0, -1, 0));
        dir_rows.push_back(row(REQ_ADD, 2, -32768, 31, -32768, 32'h55555555));
        dir_rows.push_back(row(REQ_ADD, 2, 0, 31, 0, 32'haaaaaaaa));
        dir_rows.push_back(row(REQ_READ, 2, 0, 31, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k])
            send_request(dir_rows[k].req, dir_rows[k].ch, dir_rows[k].x, dir_rows[k].y,
                         dir_rows[k].z, dir_rows[k].val, dir_rows[k].typed,
                         dir_rows[k].res);

        // Random phases, each under its own grid shape; the unused index is exercised too.
        for (int p = 0; p < 6; p++) begin
            drain();
            if (p == 5) begin
                for (int i = 0; i < 3; i++) sizes[p][i] = $urandom_range(0, 63);
            end
            write_size(CFG_SIZE_X, 6'(sizes[p][0]));
            write_size(CFG_SIZE_Y, 6'(sizes[p][1]));
            write_size(CFG_SIZE_Z, 6'(sizes[p][2]));
            write_size(2'd3, 6'($urandom()));
            span = eff_dim(size_reg[CFG_SIZE_Y]) + 1;
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                req = ($urandom_range(0, 2) == 0) ? REQ_READ : REQ_ADD;
                y = ($urandom_range(0, 6) == 0) ? pick_coord(span)
                    : $urandom_range(0, eff_dim(size_reg[CFG_SIZE_Y]) - 1);
                send_request(req, 3'($urandom_range(0, 7)), pick_coord(span), y,
                             pick_coord(span), $urandom(), 0, '0);
            end
        end

        drain();
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== periodic_grid_bin_averager_unit.f =====
rtl/pgba_pkg.sv
rtl/periodic_grid_bin_averager_unit.sv
rtl/pgba_chk.sv
tb/testbench.sv
